// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the regulator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with asynchronous active-low reset disable
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: property failed");

// Clocked implication with asynchronous active-low reset disable
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

// ----- rtl/core/dsdr_pkg.sv -----
// Types, constants and control store of the dual-switch duty regulator
package dsdr_pkg;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = 3;

  localparam logic [15:0] EdgeMargin = 16'd2000;
  localparam logic [15:0] MidDuty    = 16'hFFFF / 2;
  localparam logic [15:0] FullDuty   = 16'hFFFF;
  localparam logic [15:0] HighEdge   = FullDuty - EdgeMargin;

  typedef enum logic [2:0] {
    REG_LOOP_MODE   = 3'd0,
    REG_TARGET      = 3'd1,
    REG_TRIP_LIMIT  = 3'd2,
    REG_GAIN_MAIN   = 3'd3,
    REG_GAIN_AUX    = 3'd4,
    REG_PRESET_MAIN = 3'd5,
    REG_PRESET_AUX  = 3'd6,
    REG_PWM_PERIOD  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_CONSTANT = 2'd1,
    MODE_VOLTAGE  = 2'd2,
    MODE_CURRENT  = 2'd3
  } loop_mode_e;

  typedef enum logic [2:0] {
    STEP_IDLE     = 3'd0,
    STEP_CHECK    = 3'd1,
    STEP_MUL_ERR  = 3'd2,
    STEP_UPDATE   = 3'd3,
    STEP_MUL_MAIN = 3'd4,
    STEP_MUL_AUX  = 3'd5,
    STEP_EMIT     = 3'd6,
    STEP_SPARE    = 3'd7
  } step_e;

  typedef enum logic [2:0] {
    OP_IDLE     = 3'd0,
    OP_CHECK    = 3'd1,
    OP_MUL_ERR  = 3'd2,
    OP_UPDATE   = 3'd3,
    OP_MUL_MAIN = 3'd4,
    OP_MUL_AUX  = 3'd5,
    OP_EMIT     = 3'd6
  } dp_op_e;

  typedef enum logic [2:0] {
    J_NEXT   = 3'd0,
    J_IDLE   = 3'd1,
    J_TRIP   = 3'd2,
    J_OUT    = 3'd3,
    J_ALWAYS = 3'd4
  } jcond_e;

  typedef enum logic [1:0] {
    UPD_MID      = 2'd0,
    UPD_AUX_SUB  = 2'd1,
    UPD_AUX_ADD  = 2'd2,
    UPD_MAIN_SUB = 2'd3
  } upd_e;

  typedef struct packed {
    dp_op_e op;
    jcond_e cond;
    step_e  target;
  } ctrl_word_t;

  typedef struct packed {
    logic [11:0] voltage_sample;
    logic [11:0] current_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_main;
    logic [15:0] duty_aux;
    logic [15:0] compare_main;
    logic [15:0] compare_aux;
    logic        limit_tripped;
  } out_item_t;

  function automatic ctrl_word_t ucode_rom(input step_e step);
    ctrl_word_t cw;
    unique case (step)
      STEP_IDLE:     cw = '{op: OP_IDLE,     cond: J_IDLE,   target: STEP_MUL_MAIN};
      STEP_CHECK:    cw = '{op: OP_CHECK,    cond: J_TRIP,   target: STEP_MUL_MAIN};
      STEP_MUL_ERR:  cw = '{op: OP_MUL_ERR,  cond: J_NEXT,   target: STEP_IDLE};
      STEP_UPDATE:   cw = '{op: OP_UPDATE,   cond: J_NEXT,   target: STEP_IDLE};
      STEP_MUL_MAIN: cw = '{op: OP_MUL_MAIN, cond: J_NEXT,   target: STEP_IDLE};
      STEP_MUL_AUX:  cw = '{op: OP_MUL_AUX,  cond: J_NEXT,   target: STEP_IDLE};
      STEP_EMIT:     cw = '{op: OP_EMIT,     cond: J_OUT,    target: STEP_IDLE};
      default:       cw = '{op: OP_IDLE,     cond: J_ALWAYS, target: STEP_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ----- rtl/core/dual_switch_duty_regulator_top.sv -----
// Dual-switch duty regulator: APB registers, microcoded sequencer, shared multiplier
//
// Usage:
//   Input channel carries one voltage/current ADC word (in_valid_i, in_stall_o).
//   Output channel carries both duties, their PWM compare values and the trip
//   flag (out_valid_o, out_stall_i). Registers are written over the APB port;
//   the user must write them only while no word is in flight; the block does not enforce this.
//   Each word runs through a 7-step microprogram sharing one 17x25 multiplier:
//   feedback modes run check, error product, update, the two compare products
//   and emit; a limit trip skips the error product and update, and disabled and
//   constant modes also skip the check. The next word is accepted only once the
//   sequencer is back in idle after the result loads, so words never overlap.
//   The single multiplier is shared in turn: the error product (feedback, no
//   trip) before the update, then the two compare products, one per cycle.
//   A finished result sits in the output register; the sequencer holds in its
//   last step while that register is full and stalled, and input stays stalled.
//   Reset clears duties to zero, loads register defaults (trip limit 65535,
//   gains 1.0, period 400) and empties the output register.
module dual_switch_duty_regulator_top
  import dsdr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

`include "assert_macros.svh"

  logic [1:0]  loop_mode_q;
  logic [15:0] target_q, trip_limit_q, preset_main_q, preset_aux_q, period_q;
  logic [23:0] gain_main_q, gain_aux_q;
  logic [15:0] main_q, aux_q;
  logic [15:0] main_d, aux_d;

  step_e       step_q, step_d;
  ctrl_word_t  cw;
  logic        in_fire, out_load, feedback, trip_now;
  logic        trip_q;
  logic [11:0] sample_v_q, sample_c_q, watched, sensed;
  logic signed [16:0] err_q, err_d;
  logic signed [16:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [41:0] prod_q;
  logic [15:0] cmp_main_q;
  logic        out_valid_q;
  out_item_t   out_q;
  upd_e        upd;
  logic signed [25:0] term;
  logic signed [26:0] m_s, a_s, m_n, a_n;

  logic        cfg_we;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_LOOP_MODE:   prdata = {30'd0, loop_mode_q};
      REG_TARGET:      prdata = {16'd0, target_q};
      REG_TRIP_LIMIT:  prdata = {16'd0, trip_limit_q};
      REG_GAIN_MAIN:   prdata = {8'd0, gain_main_q};
      REG_GAIN_AUX:    prdata = {8'd0, gain_aux_q};
      REG_PRESET_MAIN: prdata = {16'd0, preset_main_q};
      REG_PRESET_AUX:  prdata = {16'd0, preset_aux_q};
      REG_PWM_PERIOD:  prdata = {16'd0, period_q};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_mode_q   <= MODE_DISABLED;
      target_q      <= '0;
      trip_limit_q  <= FullDuty;
      gain_main_q   <= 24'h010000;
      gain_aux_q    <= 24'h010000;
      preset_main_q <= '0;
      preset_aux_q  <= '0;
      period_q      <= 16'd400;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LOOP_MODE:   loop_mode_q   <= pwdata[1:0];
        REG_TARGET:      target_q      <= pwdata[15:0];
        REG_TRIP_LIMIT:  trip_limit_q  <= pwdata[15:0];
        REG_GAIN_MAIN:   gain_main_q   <= pwdata[23:0];
        REG_GAIN_AUX:    gain_aux_q    <= pwdata[23:0];
        REG_PRESET_MAIN: preset_main_q <= pwdata[15:0];
        REG_PRESET_AUX:  preset_aux_q  <= pwdata[15:0];
        REG_PWM_PERIOD:  period_q      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign cw         = ucode_rom(step_q);
  assign in_stall_o = (step_q != STEP_IDLE);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign out_load   = ~out_valid_q | ~out_stall_i;
  assign feedback   = (loop_mode_q == MODE_VOLTAGE) | (loop_mode_q == MODE_CURRENT);
  assign watched    = (loop_mode_q == MODE_VOLTAGE) ? sample_c_q : sample_v_q;
  assign sensed     = (loop_mode_q == MODE_VOLTAGE) ? sample_v_q : sample_c_q;
  assign trip_now   = {4'd0, watched} > trip_limit_q;
  assign err_d      = $signed({5'd0, sensed}) - $signed({1'b0, target_q});

  always_comb begin
    step_d = step_q;
    unique case (cw.cond)
      J_NEXT:   step_d = step_e'(step_q + 3'd1);
      J_IDLE: begin
        if (in_fire) begin
          step_d = feedback ? step_e'(step_q + 3'd1) : cw.target;
        end
      end
      J_TRIP:   step_d = trip_now ? cw.target : step_e'(step_q + 3'd1);
      J_OUT: begin
        if (out_load) begin
          step_d = cw.target;
        end
      end
      J_ALWAYS: step_d = cw.target;
      default:  step_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // update selection
  always_comb begin
    priority if (err_q[16] && main_q > HighEdge && aux_q > HighEdge) begin
      upd = UPD_MID;
    end else if (err_q[16] && main_q > HighEdge) begin
      upd = UPD_AUX_SUB;
    end else if (!err_q[16] && err_q != '0 && main_q < EdgeMargin) begin
      upd = UPD_AUX_SUB;
    end else if (err_q[16] && aux_q > EdgeMargin) begin
      upd = UPD_AUX_ADD;
    end else begin
      upd = UPD_MAIN_SUB;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = err_q;
    mul_b = $signed({1'b0, gain_main_q});
    unique case (cw.op)
      OP_MUL_ERR: begin
        mul_a = err_q;
        mul_b = (upd == UPD_MAIN_SUB) ? $signed({1'b0, gain_main_q})
                                      : $signed({1'b0, gain_aux_q});
      end
      OP_MUL_MAIN: begin
        mul_a = $signed({1'b0, main_q});
        mul_b = $signed({9'd0, period_q});
      end
      OP_MUL_AUX: begin
        mul_a = $signed({1'b0, aux_q});
        mul_b = $signed({9'd0, period_q});
      end
      default: ;
    endcase
  end

  assign term = prod_q[41:16];
  assign m_s  = $signed({11'd0, main_q});
  assign a_s  = $signed({11'd0, aux_q});

  function automatic logic [15:0] sat16(input logic signed [26:0] v);
    logic [15:0] r;
    if (v[26]) begin
      r = '0;
    end else if (v[25:16] != '0) begin
      r = FullDuty;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    m_n = m_s;
    a_n = a_s;
    unique case (upd)
      UPD_MID: begin
        m_n = $signed({11'd0, MidDuty});
        a_n = $signed({11'd0, MidDuty});
      end
      UPD_AUX_SUB:  a_n = a_s - 27'(term);
      UPD_AUX_ADD:  a_n = a_s + 27'(term);
      UPD_MAIN_SUB: m_n = m_s - 27'(term);
      default: ;
    endcase
    if (a_n > m_n) begin
      a_n = m_n;
    end
  end

  // duty state
  always_comb begin
    main_d = main_q;
    aux_d  = aux_q;
    if (cfg_we && cfg_idx == REG_PRESET_MAIN) begin
      main_d = pwdata[15:0];
      aux_d  = (aux_q > pwdata[15:0]) ? pwdata[15:0] : aux_q;
    end else if (cfg_we && cfg_idx == REG_PRESET_AUX) begin
      if (pwdata[15:0] <= main_q) begin
        aux_d = pwdata[15:0];
      end
    end else if (cw.op == OP_CHECK && trip_now) begin
      main_d = {1'b0, main_q[15:1]};
      aux_d  = {1'b0, aux_q[15:1]};
    end else if (cw.op == OP_UPDATE) begin
      main_d = sat16(m_n);
      aux_d  = sat16(a_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_q <= '0;
      aux_q  <= '0;
      trip_q <= 1'b0;
    end else begin
      main_q <= main_d;
      aux_q  <= aux_d;
      if (in_fire) begin
        trip_q <= 1'b0;
      end else if (cw.op == OP_CHECK) begin
        trip_q <= trip_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_v_q <= in_item_i.voltage_sample;
      sample_c_q <= in_item_i.current_sample;
    end
    if (cw.op == OP_CHECK) begin
      err_q <= err_d;
    end
    if (cw.op == OP_MUL_ERR || cw.op == OP_MUL_MAIN || cw.op == OP_MUL_AUX) begin
      prod_q <= mul_a * mul_b;
    end
    if (cw.op == OP_MUL_AUX) begin
      cmp_main_q <= prod_q[31:16];
    end
    if (cw.op == OP_EMIT && out_load) begin
      out_q.duty_main     <= main_q;
      out_q.duty_aux      <= aux_q;
      out_q.compare_main  <= cmp_main_q;
      out_q.compare_aux   <= prod_q[31:16];
      out_q.limit_tripped <= trip_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.op == OP_EMIT && out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_CLK(a_aux_le_main, clk_i, rst_ni, aux_q <= main_q)
  `ASSERT_IMPL(a_accept_path, clk_i, rst_ni, in_fire,
               ##1 (step_q == STEP_CHECK || step_q == STEP_MUL_MAIN))
  `ASSERT_IMPL(a_result_from_emit, clk_i, rst_ni, $rose(out_valid_q),
               $past(step_q) == STEP_EMIT)
  `ASSERT_IMPL(a_trip_needs_feedback, clk_i, rst_ni, trip_q && step_q != STEP_IDLE,
               loop_mode_q[1])

endmodule
